// File: rtl/core/ritpc_pkg.sv
package ritpc_pkg;

	// image bounds used for index clamping
	localparam int MAX_COLUMNS = 2048;
	localparam int MAX_ROWS    = 64;

	// angle arithmetic
	localparam int TWO_PI_Q16  = 411775;
	localparam int U_W         = 31;           // offset angle word, Q16 rad
	localparam int RED_STEPS   = 12;           // restoring modulo steps
	localparam int ANG_W       = 20;           // signed reduced angle, Q16 rad
	localparam int CS_W        = 32;           // CORDIC x/y, Q30
	localparam int CORDIC_STEPS = 17;

	// 2*pi * 2^11 moves every Q16 angle of this block above zero
	localparam logic signed [31:0] ANG_OFFSET = 32'sd843315200;

	localparam logic signed [ANG_W-1:0] A_TWO_PI   = 20'sd411775;
	localparam logic signed [ANG_W-1:0] A_PI       = 20'sd205887;
	localparam logic signed [ANG_W-1:0] A_HALF     = 20'sd102944;
	localparam logic signed [ANG_W-1:0] A_NEG_HALF = -20'sd102944;

	localparam logic signed [CS_W-1:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [CS_W-1:0] CS_LIM      = 32'sd1074790400;

	localparam logic signed [ANG_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
		20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
		20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
		20'sd8, 20'sd4, 20'sd2, 20'sd1
	};

	localparam logic signed [33:0] COORD_MAX = 34'sd33554431;
	localparam logic signed [33:0] COORD_MIN = -34'sd33554432;

	// angle lanes
	localparam int LANE_H   = 0;
	localparam int LANE_V   = 1;
	localparam int LANE_ROT = 2;
	localparam int LANES    = 3;

	typedef enum logic [3:0] {
		REG_HSTART  = 4'd0,
		REG_HSTEP   = 4'd1,
		REG_VSTART  = 4'd2,
		REG_VSTEP   = 4'd3,
		REG_RFLOOR  = 4'd4,
		REG_RCEIL   = 4'd5,
		REG_HMODE   = 4'd6,
		REG_ROT     = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [CS_W-1:0]  x;
		logic signed [CS_W-1:0]  y;
		logic signed [ANG_W-1:0] a;
		logic                    flip;
	} cordic_t;

	// floor((p + 2^29) / 2^30)
	function automatic logic signed [33:0] rnd_q30(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = (p + 64'sd536870912) >>> 30;
		return t[33:0];
	endfunction

	function automatic logic signed [25:0] sat26(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = v;
		if (t > COORD_MAX) t = COORD_MAX;
		if (t < COORD_MIN) t = COORD_MIN;
		return t[25:0];
	endfunction

endpackage

// File: rtl/core/range_image_to_point_cloud.sv
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    column, row, range_value, intensity_in
// out      source     out_valid / out_stall  point_x, point_y, point_z, intensity_out
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while no result is held by out_stall. The pipeline depth is
// set by the angle path: a 12-step modulo chain, a fold stage, a
// 17-cell CORDIC chain and six multiply/round stages.
// Reset clears the stage valid bits and the configuration registers but the range ceiling, which it sets to all ones.
// A result held by out_stall freezes the whole pipeline and raises in_stall.
// cfg_ready is always high.
module range_image_to_point_cloud #(
	parameter int MAX_COLUMNS = ritpc_pkg::MAX_COLUMNS,
	parameter int MAX_ROWS    = ritpc_pkg::MAX_ROWS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [10:0]  column,
	input  logic [5:0]   row,
	input  logic [23:0]  range_value,
	input  logic [15:0]  intensity_in,
	output logic         out_valid,
	input  logic         out_stall,
	output logic signed [25:0] point_x,
	output logic signed [25:0] point_y,
	output logic signed [25:0] point_z,
	output logic [15:0]  intensity_out,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [3:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	localparam int NST   = 37;   // stage count including output register
	localparam int R_DLY = 31;   // range is needed at the first multiply stage
	localparam int I_DLY = 36;

	// configuration registers
	logic signed [15:0] hstart_q;
	logic [14:0]        hstep_q;
	logic signed [15:0] vstart_q;
	logic [14:0]        vstep_q;
	logic [23:0]        rfloor_q;
	logic [23:0]        rceil_q;
	logic               hmode_q;
	logic signed [15:0] rot_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstart_q <= '0;
			hstep_q  <= '0;
			vstart_q <= '0;
			vstep_q  <= '0;
			rfloor_q <= '0;
			rceil_q  <= 24'hFFFFFF;
			hmode_q  <= 1'b0;
			rot_q    <= '0;
		end else if (cfg_valid) begin
			unique case (ritpc_pkg::reg_idx_t'(cfg_index))
				ritpc_pkg::REG_HSTART: hstart_q <= cfg_data[15:0];
				ritpc_pkg::REG_HSTEP:  hstep_q  <= cfg_data[14:0];
				ritpc_pkg::REG_VSTART: vstart_q <= cfg_data[15:0];
				ritpc_pkg::REG_VSTEP:  vstep_q  <= cfg_data[14:0];
				ritpc_pkg::REG_RFLOOR: rfloor_q <= cfg_data;
				ritpc_pkg::REG_RCEIL:  rceil_q  <= cfg_data;
				ritpc_pkg::REG_HMODE:  hmode_q  <= cfg_data[0];
				ritpc_pkg::REG_ROT:    rot_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// pipeline control: everything advances together unless the output is held
	logic [NST-1:0] vld_q;
	logic           adv;

	assign adv       = !(vld_q[NST-1] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// stage 1: clamp indices, substitute bad ranges, form offset angles
	logic [10:0] col_c;
	logic [5:0]  row_c;
	logic [23:0] r_fix;
	logic [25:0] hprod;
	logic [20:0] vprod;
	logic signed [31:0] hsum, vsum, rsum;
	logic [ritpc_pkg::U_W-1:0] u_s1 [ritpc_pkg::LANES];

	always_comb begin
		col_c = (32'(column) >= MAX_COLUMNS) ? 11'(MAX_COLUMNS - 1) : column;
		row_c = (32'(row) >= MAX_ROWS) ? 6'(MAX_ROWS - 1) : row;
		r_fix = (range_value < rfloor_q || range_value >= rceil_q) ? rceil_q : range_value;
		hprod = col_c * hstep_q;
		vprod = row_c * vstep_q;
		hsum  = (($signed({6'd0, hprod}) + 32'(hstart_q)) <<< 3) + ritpc_pkg::ANG_OFFSET;
		vsum  = (($signed({11'd0, vprod}) + 32'(vstart_q)) <<< 3) + ritpc_pkg::ANG_OFFSET;
		rsum  = (32'(rot_q) <<< 3) + ritpc_pkg::ANG_OFFSET;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1[ritpc_pkg::LANE_H]   <= hsum[ritpc_pkg::U_W-1:0];
			u_s1[ritpc_pkg::LANE_V]   <= vsum[ritpc_pkg::U_W-1:0];
			u_s1[ritpc_pkg::LANE_ROT] <= rsum[ritpc_pkg::U_W-1:0];
		end
	end

	// range and intensity ride along the angle chains
	logic [23:0] r_q   [R_DLY];
	logic [15:0] int_q [I_DLY];

	always_ff @(posedge clk) begin
		if (adv) begin
			r_q[0]   <= r_fix;
			int_q[0] <= intensity_in;
			for (int k = 1; k < R_DLY; k++) r_q[k] <= r_q[k-1];
			for (int k = 1; k < I_DLY; k++) int_q[k] <= int_q[k-1];
		end
	end

	// stages 2..13: reduce each angle modulo 2*pi
	logic [ritpc_pkg::U_W-1:0] modv [ritpc_pkg::LANES][ritpc_pkg::RED_STEPS];
	ritpc_pkg::cordic_t fold_s14 [ritpc_pkg::LANES];
	ritpc_pkg::cordic_t crd [ritpc_pkg::LANES][ritpc_pkg::CORDIC_STEPS];

	// map [0, 2*pi) to [-pi/2, pi/2] plus a sign flip
	function automatic ritpc_pkg::cordic_t fold_in(input logic [ritpc_pkg::U_W-1:0] u);
		logic signed [ritpc_pkg::ANG_W-1:0] a;
		ritpc_pkg::cordic_t c;
		a = $signed({1'b0, u[ritpc_pkg::ANG_W-2:0]});
		if (a > ritpc_pkg::A_PI) a = a - ritpc_pkg::A_TWO_PI;
		c.flip = 1'b0;
		if (a > ritpc_pkg::A_HALF) begin
			a = a - ritpc_pkg::A_PI;
			c.flip = 1'b1;
		end else if (a < ritpc_pkg::A_NEG_HALF) begin
			a = a + ritpc_pkg::A_PI;
			c.flip = 1'b1;
		end
		c.x = ritpc_pkg::CORDIC_GAIN;
		c.y = '0;
		c.a = a;
		return c;
	endfunction

	for (genvar l = 0; l < ritpc_pkg::LANES; l++) begin : g_lane
		for (genvar k = 0; k < ritpc_pkg::RED_STEPS; k++) begin : g_mod
			ritpc_mod_cell #(.K(ritpc_pkg::RED_STEPS - 1 - k)) u_mod (
				.clk (clk),
				.en  (adv),
				.d   ((k == 0) ? u_s1[l] : modv[l][(k == 0) ? 0 : k-1]),
				.q   (modv[l][k])
			);
		end

		// stage 14: fold
		always_ff @(posedge clk) begin
			if (adv) begin
				fold_s14[l] <= fold_in(modv[l][ritpc_pkg::RED_STEPS-1]);
			end
		end

		// stages 15..31: CORDIC rotation cells
		for (genvar j = 0; j < ritpc_pkg::CORDIC_STEPS; j++) begin : g_cordic
			ritpc_cordic_cell #(
				.I    (j),
				.LAST (j == ritpc_pkg::CORDIC_STEPS - 1)
			) u_cell (
				.clk (clk),
				.en  (adv),
				.d   ((j == 0) ? fold_s14[l] : crd[l][(j == 0) ? 0 : j-1]),
				.q   (crd[l][j])
			);
		end
	end

	// cos/sin of each lane at the end of the chains
	logic signed [ritpc_pkg::CS_W-1:0] ch_c, sh_c, cv_c, sv_c, ca_c, sa_c;
	assign ch_c = crd[ritpc_pkg::LANE_H][ritpc_pkg::CORDIC_STEPS-1].x;
	assign sh_c = crd[ritpc_pkg::LANE_H][ritpc_pkg::CORDIC_STEPS-1].y;
	assign cv_c = crd[ritpc_pkg::LANE_V][ritpc_pkg::CORDIC_STEPS-1].x;
	assign sv_c = crd[ritpc_pkg::LANE_V][ritpc_pkg::CORDIC_STEPS-1].y;
	assign ca_c = crd[ritpc_pkg::LANE_ROT][ritpc_pkg::CORDIC_STEPS-1].x;
	assign sa_c = crd[ritpc_pkg::LANE_ROT][ritpc_pkg::CORDIC_STEPS-1].y;

	logic signed [24:0] r_ext;
	assign r_ext = $signed({1'b0, r_q[R_DLY-1]});

	// stage 32: range times vertical trig and horizontal sine
	logic signed [56:0] prcv_s32, prsv_s32, prsh_s32;
	logic signed [ritpc_pkg::CS_W-1:0] ch_s32, sh_s32, ca_s32, sa_s32;
	// stage 33: round to Q16
	logic signed [25:0] rc_s33, rs_s33, rsh_s33;
	logic signed [ritpc_pkg::CS_W-1:0] ch_s33, sh_s33, ca_s33, sa_s33;
	// stage 34: second projection products
	logic signed [57:0] px_s34, py_s34, pz_s34;
	logic signed [25:0] rs_s34, rsh_s34;
	logic signed [ritpc_pkg::CS_W-1:0] ca_s34, sa_s34;
	// stage 35: round and pick the layout
	logic signed [25:0] x_s35, y_s35, z_s35;
	logic signed [ritpc_pkg::CS_W-1:0] ca_s35, sa_s35;
	// stage 36: rotation products
	logic signed [57:0] pxc_s36, pys_s36, pxs_s36, pyc_s36;
	logic signed [25:0] z_s36;

	logic signed [58:0] rx_sum, ry_sum;
	assign rx_sum = 59'(pxc_s36) - 59'(pys_s36);
	assign ry_sum = 59'(pxs_s36) + 59'(pyc_s36);

	always_ff @(posedge clk) begin
		if (adv) begin
			prcv_s32 <= r_ext * cv_c;
			prsv_s32 <= r_ext * sv_c;
			prsh_s32 <= r_ext * sh_c;
			ch_s32 <= ch_c;
			sh_s32 <= sh_c;
			ca_s32 <= ca_c;
			sa_s32 <= sa_c;

			rc_s33  <= 26'(ritpc_pkg::rnd_q30(64'(prcv_s32)));
			rs_s33  <= 26'(ritpc_pkg::rnd_q30(64'(prsv_s32)));
			rsh_s33 <= 26'(ritpc_pkg::rnd_q30(64'(prsh_s32)));
			ch_s33 <= ch_s32;
			sh_s33 <= sh_s32;
			ca_s33 <= ca_s32;
			sa_s33 <= sa_s32;

			px_s34  <= rc_s33 * ch_s33;
			py_s34  <= rc_s33 * sh_s33;
			pz_s34  <= rs_s33 * ch_s33;
			rs_s34  <= rs_s33;
			rsh_s34 <= rsh_s33;
			ca_s34  <= ca_s33;
			sa_s34  <= sa_s33;

			x_s35 <= 26'(ritpc_pkg::rnd_q30(64'(px_s34)));
			if (hmode_q) begin
				y_s35 <= rsh_s34;
				z_s35 <= 26'(ritpc_pkg::rnd_q30(64'(pz_s34)));
			end else begin
				y_s35 <= 26'(ritpc_pkg::rnd_q30(64'(py_s34)));
				z_s35 <= rs_s34;
			end
			ca_s35 <= ca_s34;
			sa_s35 <= sa_s34;

			pxc_s36 <= ca_s35 * x_s35;
			pys_s36 <= sa_s35 * y_s35;
			pxs_s36 <= sa_s35 * x_s35;
			pyc_s36 <= ca_s35 * y_s35;
			z_s36   <= z_s35;

			// stage 37: final rotation sum, round and saturate
			point_x <= ritpc_pkg::sat26(ritpc_pkg::rnd_q30(64'(rx_sum)));
			point_y <= ritpc_pkg::sat26(ritpc_pkg::rnd_q30(64'(ry_sum)));
			point_z <= ritpc_pkg::sat26(34'(z_s36));
			intensity_out <= int_q[I_DLY-1];
		end
	end

	// a held output must freeze every stage valid bit
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved while the output was held");

	// folded horizontal angle stays within a quarter turn
	a_fold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[13] |-> (fold_s14[ritpc_pkg::LANE_H].a <= ritpc_pkg::A_HALF &&
			fold_s14[ritpc_pkg::LANE_H].a >= ritpc_pkg::A_NEG_HALF))
		else $error("fold stage left angle outside a quarter turn");

	// CORDIC cosine stays near unit magnitude
	a_cos: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[30] |-> (ch_c <= ritpc_pkg::CS_LIM && ch_c >= -ritpc_pkg::CS_LIM))
		else $error("CORDIC cosine out of range");

endmodule

// File: rtl/core/ritpc_mod_cell.sv
module ritpc_mod_cell #(
	parameter int K = 0
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ritpc_pkg::U_W-1:0]   d,
	output logic [ritpc_pkg::U_W-1:0]   q
);

	localparam longint unsigned SUB_L = longint'(ritpc_pkg::TWO_PI_Q16) << K;
	localparam logic [ritpc_pkg::U_W-1:0] SUB = SUB_L[ritpc_pkg::U_W-1:0];

	// drop one multiple of 2*pi*2^K when it fits
	always_ff @(posedge clk) begin
		if (en) begin
			q <= (d >= SUB) ? d - SUB : d;
		end
	end

endmodule

// File: rtl/core/ritpc_cordic_cell.sv
module ritpc_cordic_cell #(
	parameter int I    = 0,
	parameter bit LAST = 1'b0
) (
	input  logic                 clk,
	input  logic                 en,
	input  ritpc_pkg::cordic_t   d,
	output ritpc_pkg::cordic_t   q
);

	ritpc_pkg::cordic_t nxt;
	logic signed [ritpc_pkg::CS_W-1:0] xs;
	logic signed [ritpc_pkg::CS_W-1:0] ys;

	always_comb begin
		xs = d.x >>> I;
		ys = d.y >>> I;
		nxt = d;
		if (!d.a[ritpc_pkg::ANG_W-1]) begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.a = d.a - ritpc_pkg::ATAN_Q16[I];
		end else begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.a = d.a + ritpc_pkg::ATAN_Q16[I];
		end
		// undo the half-turn fold on the way out
		if (LAST && d.flip) begin
			nxt.x = -nxt.x;
			nxt.y = -nxt.y;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// File: tb/ritpc_checker.sv
`timescale 1ns / 1ps

module ritpc_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_stall,
	input  logic [10:0]  column,
	input  logic [5:0]   row,
	input  logic [23:0]  range_value,
	input  logic [15:0]  intensity_in,
	input  logic         out_valid,
	input  logic         out_stall,
	input  logic signed [25:0] point_x,
	input  logic signed [25:0] point_y,
	input  logic signed [25:0] point_z,
	input  logic [15:0]  intensity_out,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [3:0]   cfg_index,
	input  logic [23:0]  cfg_data,
	output int           errors,
	output int           pending,
	output int           points_seen
);

	typedef struct packed {
		logic signed [25:0] x;
		logic signed [25:0] y;
		logic signed [25:0] z;
		logic [15:0]        inten;
	} point_t;

	point_t expected_points[$];

	logic [15:0] h_start, v_start, rot;
	logic [14:0] h_step, v_step;
	logic [23:0] r_floor, r_ceil;
	logic        h_mode;

	assign pending = expected_points.size();

	function automatic longint rnd30(input longint p);
		return (p + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic logic signed [25:0] clip26(input longint v);
		if (v > 33554431) v = 33554431;
		if (v < -33554432) v = -33554432;
		return v[25:0];
	endfunction

	// Q13 angle -> cos/sin in Q30
	function automatic void cos_sin(input longint a13, output longint c, output longint s);
		longint a, x, y, nx;
		bit flip;
		flip = 0;
		a = (a13 * 8) % ritpc_pkg::TWO_PI_Q16;
		if (a < 0) a += ritpc_pkg::TWO_PI_Q16;
		if (a > 205887) a -= ritpc_pkg::TWO_PI_Q16;
		if (a > 102944) begin
			a -= 205887;
			flip = 1;
		end else if (a < -102944) begin
			a += 205887;
			flip = 1;
		end
		x = ritpc_pkg::CORDIC_GAIN;
		y = 0;
		for (int i = 0; i < ritpc_pkg::CORDIC_STEPS; i++) begin
			if (a >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				a -= longint'(ritpc_pkg::ATAN_Q16[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				a += longint'(ritpc_pkg::ATAN_Q16[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic point_t project_point(input logic [10:0] col, input logic [5:0] rw,
			input logic [23:0] rng, input logic [15:0] inten);
		longint r, ha, va, ch, sh, cv, sv, ca, sa, rc, x, y, z;
		point_t p;
		r = rng;
		if (rng < r_floor || rng >= r_ceil) r = r_ceil;
		ha = longint'(col) * longint'(h_step) + longint'($signed(h_start));
		va = longint'(rw) * longint'(v_step) + longint'($signed(v_start));
		cos_sin(ha, ch, sh);
		cos_sin(va, cv, sv);
		cos_sin(longint'($signed(rot)), ca, sa);
		rc = rnd30(r * cv);
		x = rnd30(rc * ch);
		if (h_mode) begin
			y = rnd30(r * sh);
			z = rnd30(rnd30(r * sv) * ch);
		end else begin
			y = rnd30(rc * sh);
			z = rnd30(r * sv);
		end
		p.x = clip26(rnd30(ca * x - sa * y));
		p.y = clip26(rnd30(sa * x + ca * y));
		p.z = clip26(z);
		p.inten = inten;
		return p;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		points_seen = 0;
	end

	// track register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_start <= '0;
			h_step  <= '0;
			v_start <= '0;
			v_step  <= '0;
			r_floor <= '0;
			r_ceil  <= 24'hFFFFFF;
			h_mode  <= 1'b0;
			rot     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ritpc_pkg::REG_HSTART: h_start <= cfg_data[15:0];
				ritpc_pkg::REG_HSTEP:  h_step  <= cfg_data[14:0];
				ritpc_pkg::REG_VSTART: v_start <= cfg_data[15:0];
				ritpc_pkg::REG_VSTEP:  v_step  <= cfg_data[14:0];
				ritpc_pkg::REG_RFLOOR: r_floor <= cfg_data;
				ritpc_pkg::REG_RCEIL:  r_ceil  <= cfg_data;
				ritpc_pkg::REG_HMODE:  h_mode  <= cfg_data[0];
				ritpc_pkg::REG_ROT:    rot     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		point_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_points.insert(expected_points.size(),
					project_point(column, row, range_value, intensity_in));
			if (out_valid && !out_stall) begin
				points_seen++;
				if (expected_points.size() == 0) begin
					report("unexpected point", points_seen, 0);
				end else begin
					want = expected_points.pop_front();
					if (point_x !== want.x) report("point_x", point_x, want.x);
					if (point_y !== want.y) report("point_y", point_y, want.y);
					if (point_z !== want.z) report("point_z", point_z, want.z);
					if (intensity_out !== want.inten)
						report("intensity_out", intensity_out, want.inten);
				end
			end
		end
	end

endmodule

// File: tb/tb_range_image_to_point_cloud.sv
`timescale 1ns / 1ps

module tb_range_image_to_point_cloud;

	localparam int LIMIT = 600000;
	localparam int DRAIN = 60;

	logic clk = 0;
	logic arst_n;
	logic in_valid, in_stall;
	logic [10:0] column;
	logic [5:0] row;
	logic [23:0] range_value;
	logic [15:0] intensity_in;
	logic out_valid, out_stall;
	logic signed [25:0] point_x, point_y, point_z;
	logic [15:0] intensity_out;
	logic cfg_valid, cfg_ready;
	logic [3:0] cfg_index;
	logic [23:0] cfg_data;

	int errors, pending, points_seen;
	int cycles = 0;
	int sent = 0;
	bit calm = 0;       // no idling on either side while set
	bit hold_req = 0;   // ask the receiver for one long hold-off
	bit hold_done = 0;
	logic [23:0] lo_r, hi_r;

	always #5 clk = ~clk;

	range_image_to_point_cloud dut (.*);

	ritpc_checker u_checker (.*);

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d points outstanding", cycles, pending);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver side: random stalls, one long hold-off that backs the pipe up into in_stall.
	initial begin
		int n;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1;
				out_stall <= 1;
				repeat (299) @(posedge clk);
			end else if (calm || $urandom_range(0, 9) < 6) begin
				out_stall <= 0;
			end else begin
				out_stall <= 1;
				n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
				repeat (n - 1) @(posedge clk);
			end
		end
	end

	// Write one register; the block must be idle. The caller drops cfg_valid.
	task automatic write_reg(input logic [3:0] idx, input logic [23:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Stop offering, let every outstanding point come out, then give the pipe its full depth.
	task automatic drain;
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic load_regs(input logic [15:0] hs, input logic [14:0] hp,
			input logic [15:0] vs, input logic [14:0] vp, input logic [23:0] fl,
			input logic [23:0] cl, input logic md, input logic [15:0] ro);
		drain();
		write_reg(ritpc_pkg::REG_HSTART, {8'h00, hs});
		write_reg(ritpc_pkg::REG_HSTEP, {9'h000, hp});
		write_reg(ritpc_pkg::REG_VSTART, {8'h00, vs});
		write_reg(ritpc_pkg::REG_VSTEP, {9'h000, vp});
		write_reg(ritpc_pkg::REG_RFLOOR, fl);
		write_reg(ritpc_pkg::REG_RCEIL, cl);
		write_reg(ritpc_pkg::REG_HMODE, {23'h0, md});
		write_reg(ritpc_pkg::REG_ROT, {8'h00, ro});
		cfg_valid <= 0;
	endtask

	// Offer one sample; keep valid up if no gap follows.
	task automatic send_point(input logic [10:0] c, input logic [5:0] r,
			input logic [23:0] rng, input logic [15:0] it);
		int gap;
		in_valid     <= 1;
		column       <= c;
		row          <= r;
		range_value  <= rng;
		intensity_in <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		if (sent == 400) hold_req = 1;
		gap = 0;
		if (!calm) begin
			if ($urandom_range(0, 9) >= 6)
				gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		end
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_range_in(input logic [23:0] fl, input logic [23:0] cl,
			output logic [23:0] rng);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6 && cl > fl)
			rng = fl + 24'($urandom_range(0, cl - fl - 1));
		else if (pick < 7)
			rng = fl;
		else if (pick < 8)
			rng = cl;
		else
			rng = 24'($urandom);
	endtask

	initial begin
		logic [15:0] hs, vs, ro;
		logic [14:0] hp, vp;
		logic [23:0] rng;
		logic md;
		arst_n = 0;
		in_valid = 0;
		column = 0;
		row = 0;
		range_value = 0;
		intensity_in = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Two points with the reset configuration.
		send_point(11'd5, 6'd3, 24'h010000, 16'h1234);
		send_point(11'd2047, 6'd63, 24'hFFFFFF, 16'hFFFF);

		// Directed: a sensor-like sweep, range gate edges, field extremes.
		load_regs(-16'sd25736, 15'd25, -16'sd3000, 15'd100, 24'h010000, 24'h500000, 1'b0, 16'd0);
		// writes to undefined indexes must not disturb anything
		for (int k = 0; k < 8; k++)
			write_reg(4'(ritpc_pkg::REG_ROT) + 4'd1 + 4'(k), 24'($urandom));
		cfg_valid <= 0;
		send_point(11'd0, 6'd0, 24'h000000, 16'h0000);
		send_point(11'd2047, 6'd63, 24'h00FFFF, 16'hFFFF);
		send_point(11'd1024, 6'd32, 24'h010000, 16'h5555);
		send_point(11'd512, 6'd10, 24'h4FFFFF, 16'hAAAA);
		send_point(11'd1536, 6'd20, 24'h500000, 16'h0001);
		send_point(11'd1, 6'd1, 24'hFFFFFF, 16'h8000);
		send_point(11'd1023, 6'd31, 24'h123456, 16'h7FFF);
		// horizontal layout with a rotation
		load_regs(-16'sd25736, 15'd25, -16'sd3000, 15'd100, 24'h000000, 24'hFFFFFF, 1'b1, 16'sd6434);
		send_point(11'd0, 6'd0, 24'hFFFFFE, 16'h0F0F);
		send_point(11'd2047, 6'd63, 24'h000001, 16'hF0F0);
		send_point(11'd700, 6'd40, 24'h800000, 16'h3C3C);
		// floor above ceiling: every range becomes the ceiling
		load_regs(16'sd1000, 15'd7, 16'sd500, 15'd3, 24'hFFFFFF, 24'h000000, 1'b0, -16'sd32768);
		send_point(11'd3, 6'd2, 24'h000000, 16'h0101);
		send_point(11'd2000, 6'd60, 24'hFFFFFF, 16'h0202);
		// largest angles wrap many turns
		load_regs(16'h8000, 15'h7FFF, 16'h7FFF, 15'h7FFF, 24'h000000, 24'hFFFFFF, 1'b1, 16'h7FFF);
		send_point(11'd2047, 6'd63, 24'hFFFFFE, 16'hFFFF);
		send_point(11'd0, 6'd0, 24'hFFFFFE, 16'h0000);
		send_point(11'd1234, 6'd17, 24'h7FFFFF, 16'h4321);
		load_regs(16'h7FFF, 15'h7FFF, 16'h8000, 15'h0000, 24'h000000, 24'hFFFFFF, 1'b0, 16'h8000);
		send_point(11'd2047, 6'd63, 24'hFFFFFE, 16'hFFFF);
		send_point(11'd1, 6'd0, 24'hC00000, 16'h00FF);

		// Random phases: sensor-like and fully random settings in turn.
		for (int ph = 0; ph < 6; ph++) begin
			if (ph % 2 == 0) begin
				hp = 15'($urandom_range(1, 60));
				hs = 16'(-(int'(hp) * 1024) + $urandom_range(0, 200) - 100);
				vp = 15'($urandom_range(20, 300));
				vs = 16'(-(int'(vp) * 32));
				lo_r = 24'($urandom_range(0, 24'h040000));
				hi_r = 24'($urandom_range(24'h400000, 24'hFFFFFF));
				ro = 16'($urandom_range(0, 16000) - 8000);
			end else begin
				hs = 16'($urandom);
				hp = 15'($urandom);
				vs = 16'($urandom);
				vp = 15'($urandom);
				lo_r = 24'($urandom);
				hi_r = 24'($urandom);
				ro = 16'($urandom);
			end
			md = ph[1] ^ ph[0];
			load_regs(hs, hp, vs, vp, lo_r, hi_r, md, ro);
			calm = (ph == 2);
			for (int i = 0; i < 240; i++) begin
				random_range_in(lo_r, hi_r, rng);
				send_point(11'($urandom), 6'($urandom), rng, 16'($urandom));
			end
			calm = 0;
		end

		drain();
		$display("%0d samples sent through several angle, gate, layout and rotation settings;",
			sent);
		$display("%0d points checked, including a long output hold-off", points_seen);
		if (errors == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
